FILE: design/w2s_pkg.sv
// Shared widths, register codes, reset values, pipeline types and helper functions
// for the world-to-screen projection pipeline. No dependencies.
package w2s_pkg;

    localparam int COORD_W    = 32;   // Q16.16 point and result
    localparam int PROD_W     = 48;   // coeff * pos after the floor shift by 16
    localparam int PSUM_W     = 49;   // sum of two terms
    localparam int CLIP_W     = 50;   // clip coordinate accumulator
    localparam int WIN_W      = 14;   // window size register
    localparam int HALF_W     = 13;   // half window size
    localparam int SPLIT_W    = 25;   // magnitude split for the half multiply
    localparam int PP_W       = SPLIT_W + HALF_W;
    localparam int NUM_W      = 63;   // |clip| * half
    localparam int DEN_W      = 49;   // clip w as divisor
    localparam int FRAC_W     = 16;
    localparam int LOW_W      = 24;   // integer quotient bits before clamping
    localparam int QUO_W      = LOW_W + FRAC_W;
    localparam int TERM_W     = QUO_W + 1;
    localparam int SUM_W      = 43;
    localparam int DIV_STEPS  = QUO_W;
    localparam int FRONT_STGS = 7;
    localparam int BACK_STGS  = 2;
    localparam int STAGES     = FRONT_STGS + DIV_STEPS + BACK_STGS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ROWS       = 3;
    localparam int LANES      = 2;
    localparam int COEFS      = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIN_W   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_H   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XB = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YB = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_WA = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_WB = 3'd7;

    localparam logic [WIN_W-1:0]      RST_WIN_W = 14'd1920;
    localparam logic [WIN_W-1:0]      RST_WIN_H = 14'd1080;
    localparam logic [CFG_DATA_W-1:0] RST_ONE_LO = 64'h0000_0000_0001_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ONE_HI = 64'h0001_0000_0000_0000;

    localparam logic signed [CLIP_W-1:0] VIS_MIN    = 50'sd6554;   // least Q16.16 >= 0.1
    localparam logic [TERM_W-1:0]        TERM_CLAMP = 41'h100_0000_0000;
    localparam logic signed [SUM_W-1:0]  SAT_HI     = 43'sd2147483647;
    localparam logic signed [SUM_W-1:0]  SAT_LO     = -43'sd2147483648;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [LOW_W-1:0] low;    // dividend bits still to bring down
        logic             clamp;
        logic             neg;
    } t_lane;

    typedef struct packed {
        t_lane [LANES-1:0] lane;
        logic [DEN_W-1:0]  d;
        logic              vis;
    } t_div;

    function automatic t_lane seed_lane(logic [NUM_W-1:0] m, logic [DEN_W-1:0] d,
                                        logic neg);
        t_lane b;
        b.clamp = {{(DEN_W + LOW_W - NUM_W){1'b0}}, m} >= {d, {LOW_W{1'b0}}};
        b.rem   = {{(DEN_W - NUM_W + LOW_W){1'b0}}, m[NUM_W-1:LOW_W]};
        b.low   = m[LOW_W-1:0];
        b.quo   = '0;
        b.neg   = neg;
        return b;
    endfunction

    // One restoring division step: bring down one bit, subtract if it fits.
    function automatic t_lane lane_step(t_lane a, logic [DEN_W-1:0] d);
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        t_lane          b;
        trial = {a.rem, a.low[LOW_W-1]};
        diff  = trial - {1'b0, d};
        b     = a;
        b.low = {a.low[LOW_W-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
            b.rem = diff[DEN_W-1:0];
            b.quo = {a.quo[QUO_W-2:0], 1'b1};
        end else begin
            b.rem = trial[DEN_W-1:0];
            b.quo = {a.quo[QUO_W-2:0], 1'b0};
        end
        return b;
    endfunction

    function automatic t_div div_step(t_div a);
        t_div b;
        b         = a;
        b.lane[0] = lane_step(a.lane[0], a.d);
        b.lane[1] = lane_step(a.lane[1], a.d);
        return b;
    endfunction

    function automatic logic [COORD_W-1:0] sat_q16(logic signed [SUM_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[COORD_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: design/world_to_screen_projection.sv
// Top level of the world-to-screen projection pipeline: matrix rows, visibility test,
// pipelined divide and window mapping. Depends on w2s_pkg.

// One point enters per clock while o_stall is low. An accepted beat passes through
// seven stages of row multiply, row sums and scaling by the half window,
// forty one-bit steps of the shared divide by clip w (x and y lanes side by side), then
// the window offset and saturation into the output register. The whole pipe holds
// while a finished beat waits on i_stall; bubbles travel with it. Configuration
// writes are always ready; make them only while the pipe is empty, as the half window
// is read several stages after the matrix rows.
module world_to_screen_projection (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [w2s_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [w2s_pkg::COORD_W-1:0]   i_pos_y,
    input  logic signed [w2s_pkg::COORD_W-1:0]   i_pos_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_on_screen,
    output logic signed [w2s_pkg::COORD_W-1:0]   o_screen_x,
    output logic signed [w2s_pkg::COORD_W-1:0]   o_screen_y,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [w2s_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [w2s_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic [w2s_pkg::WIN_W-1:0]      r_win_w;
    logic [w2s_pkg::WIN_W-1:0]      r_win_h;
    logic [w2s_pkg::CFG_DATA_W-1:0] r_coef [0:w2s_pkg::COEFS-1];
    logic [w2s_pkg::HALF_W-1:0]     half [0:w2s_pkg::LANES-1];

    logic                           en;
    logic [w2s_pkg::STAGES-1:0]     r_vld;

    logic signed [2*w2s_pkg::COORD_W-1:0] row_prod [0:w2s_pkg::ROWS-1][0:2];
    logic signed [w2s_pkg::PROD_W-1:0]    r1_p [0:w2s_pkg::ROWS-1][0:2];
    logic signed [w2s_pkg::COORD_W-1:0]   r1_t [0:w2s_pkg::ROWS-1];
    logic signed [w2s_pkg::PSUM_W-1:0]    r2_a [0:w2s_pkg::ROWS-1];
    logic signed [w2s_pkg::PSUM_W-1:0]    r2_b [0:w2s_pkg::ROWS-1];
    logic signed [w2s_pkg::CLIP_W-1:0]    r3_c [0:w2s_pkg::ROWS-1];

    logic                           r4_vis;
    logic [w2s_pkg::DEN_W-1:0]      r4_d;
    logic [w2s_pkg::CLIP_W-1:0]     r4_mag [0:w2s_pkg::LANES-1];
    logic                           r4_neg [0:w2s_pkg::LANES-1];
    logic                           r5_vis;
    logic [w2s_pkg::DEN_W-1:0]      r5_d;
    logic [w2s_pkg::PP_W-1:0]       r5_plo [0:w2s_pkg::LANES-1];
    logic [w2s_pkg::PP_W-1:0]       r5_phi [0:w2s_pkg::LANES-1];
    logic                           r5_neg [0:w2s_pkg::LANES-1];
    logic                           r6_vis;
    logic [w2s_pkg::DEN_W-1:0]      r6_d;
    logic [w2s_pkg::NUM_W-1:0]      r6_m [0:w2s_pkg::LANES-1];
    logic                           r6_neg [0:w2s_pkg::LANES-1];

    w2s_pkg::t_div                  n7;
    w2s_pkg::t_div                  r7;
    w2s_pkg::t_div                  r_dv [0:w2s_pkg::DIV_STEPS-1];

    logic                           r_f1_vis;
    logic signed [w2s_pkg::SUM_W-1:0] r_f1_sum [0:w2s_pkg::LANES-1];
    logic [w2s_pkg::COORD_W-1:0]    r_out [0:w2s_pkg::LANES-1];
    logic                           r_out_vis;

    // Hold the whole pipe only while the output beat is refused
    assign en          = !(r_vld[w2s_pkg::STAGES-1] && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vld[w2s_pkg::STAGES-1];
    assign o_on_screen = r_out_vis;
    assign o_screen_x  = r_out[0];
    assign o_screen_y  = r_out[1];
    assign half[0]     = r_win_w[w2s_pkg::WIN_W-1:1];
    assign half[1]     = r_win_h[w2s_pkg::WIN_W-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_w   <= w2s_pkg::RST_WIN_W;
            r_win_h   <= w2s_pkg::RST_WIN_H;
            r_coef[0] <= w2s_pkg::RST_ONE_LO;
            r_coef[1] <= '0;
            r_coef[2] <= w2s_pkg::RST_ONE_HI;
            r_coef[3] <= '0;
            r_coef[4] <= '0;
            r_coef[5] <= w2s_pkg::RST_ONE_HI;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                w2s_pkg::REG_WIN_W:   r_win_w   <= i_cfg_data[w2s_pkg::WIN_W-1:0];
                w2s_pkg::REG_WIN_H:   r_win_h   <= i_cfg_data[w2s_pkg::WIN_W-1:0];
                w2s_pkg::REG_COEF_XA: r_coef[0] <= i_cfg_data;
                w2s_pkg::REG_COEF_XB: r_coef[1] <= i_cfg_data;
                w2s_pkg::REG_COEF_YA: r_coef[2] <= i_cfg_data;
                w2s_pkg::REG_COEF_YB: r_coef[3] <= i_cfg_data;
                w2s_pkg::REG_COEF_WA: r_coef[4] <= i_cfg_data;
                w2s_pkg::REG_COEF_WB: r_coef[5] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[w2s_pkg::STAGES-2:0], i_valid};
        end
    end

    // Matrix rows: products, floor shift, then a two-level adder
    for (genvar r = 0; r < w2s_pkg::ROWS; r++) begin : g_row
        assign row_prod[r][0] = 64'($signed(r_coef[2*r][31:0]))  * 64'(i_pos_x);
        assign row_prod[r][1] = 64'($signed(r_coef[2*r][63:32])) * 64'(i_pos_y);
        assign row_prod[r][2] = 64'($signed(r_coef[2*r+1][31:0])) * 64'(i_pos_z);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r1_p[r][0] <= row_prod[r][0][2*w2s_pkg::COORD_W-1:w2s_pkg::FRAC_W];
                r1_p[r][1] <= row_prod[r][1][2*w2s_pkg::COORD_W-1:w2s_pkg::FRAC_W];
                r1_p[r][2] <= row_prod[r][2][2*w2s_pkg::COORD_W-1:w2s_pkg::FRAC_W];
                r1_t[r]    <= $signed(r_coef[2*r+1][63:32]);
                r2_a[r]    <= 49'(r1_p[r][0]) + 49'(r1_p[r][1]);
                r2_b[r]    <= 49'(r1_p[r][2]) + 49'(r1_t[r]);
                r3_c[r]    <= 50'(r2_a[r]) + 50'(r2_b[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_vis <= r3_c[2] >= w2s_pkg::VIS_MIN;
            r4_d   <= r3_c[2][w2s_pkg::DEN_W-1:0];
            r5_vis <= r4_vis;
            r5_d   <= r4_d;
            r6_vis <= r5_vis;
            r6_d   <= r5_d;
            r7     <= n7;
        end
    end

    // Scale |clip| by the half window in two partial products, then merge
    for (genvar l = 0; l < w2s_pkg::LANES; l++) begin : g_scale
        always_ff @(posedge i_clk) begin
            if (en) begin
                r4_neg[l] <= r3_c[l][w2s_pkg::CLIP_W-1];
                r4_mag[l] <= r3_c[l][w2s_pkg::CLIP_W-1] ? 50'(-r3_c[l]) : 50'(r3_c[l]);
                r5_neg[l] <= r4_neg[l];
                r5_plo[l] <= {{w2s_pkg::HALF_W{1'b0}}, r4_mag[l][w2s_pkg::SPLIT_W-1:0]}
                             * {{w2s_pkg::SPLIT_W{1'b0}}, half[l]};
                r5_phi[l] <= {{w2s_pkg::HALF_W{1'b0}},
                              r4_mag[l][w2s_pkg::CLIP_W-1:w2s_pkg::SPLIT_W]}
                             * {{w2s_pkg::SPLIT_W{1'b0}}, half[l]};
                r6_neg[l] <= r5_neg[l];
                r6_m[l]   <= {{w2s_pkg::SPLIT_W{1'b0}}, r5_plo[l]}
                             + {r5_phi[l], {w2s_pkg::SPLIT_W{1'b0}}};
            end
        end
    end

    always_comb begin
        n7.d       = r6_d;
        n7.vis     = r6_vis;
        n7.lane[0] = w2s_pkg::seed_lane(r6_m[0], r6_d, r6_neg[0]);
        n7.lane[1] = w2s_pkg::seed_lane(r6_m[1], r6_d, r6_neg[1]);
    end

    // One quotient bit per stage for both lanes
    for (genvar j = 0; j < w2s_pkg::DIV_STEPS; j++) begin : g_div
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv[j] <= w2s_pkg::div_step(r7);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv[j] <= w2s_pkg::div_step(r_dv[j-1]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_vis  <= r_dv[w2s_pkg::DIV_STEPS-1].vis;
            r_out_vis <= r_f1_vis;
        end
    end

    // Offset by the half window: x adds the signed term, y subtracts it
    for (genvar l = 0; l < w2s_pkg::LANES; l++) begin : g_map
        logic [w2s_pkg::TERM_W-1:0] term;
        logic [w2s_pkg::SUM_W-1:0]  base;
        logic                       add;

        assign term = r_dv[w2s_pkg::DIV_STEPS-1].lane[l].clamp ? w2s_pkg::TERM_CLAMP
                      : {1'b0, r_dv[w2s_pkg::DIV_STEPS-1].lane[l].quo};
        assign base = {{(w2s_pkg::SUM_W - w2s_pkg::HALF_W - w2s_pkg::FRAC_W){1'b0}},
                       half[l], {w2s_pkg::FRAC_W{1'b0}}};
        assign add  = (l == 0) ? !r_dv[w2s_pkg::DIV_STEPS-1].lane[l].neg
                               : r_dv[w2s_pkg::DIV_STEPS-1].lane[l].neg;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_f1_sum[l] <= add ? $signed(base + {2'b00, term})
                                   : $signed(base - {2'b00, term});
                r_out[l]    <= r_f1_vis ? w2s_pkg::sat_q16(r_f1_sum[l]) : '0;
            end
        end
    end

endmodule

FILE: design/w2s_checker.sv
// Port-level checks for the world-to-screen projection pipeline, bound to its top level.
// Depends only on the ports of world_to_screen_projection.
module w2s_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_on_screen,
    input logic [31:0] o_screen_x,
    input logic [31:0] o_screen_y
);

    // Hidden points carry zero coordinates
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_on_screen |-> o_screen_x == 32'd0 && o_screen_y == 32'd0)
        else $error("hidden beat with non-zero coordinates");

    // Input is held back exactly when the output beat is refused
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output back-pressure");

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat straight after reset");

    // A refused result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_on_screen)
            && $stable(o_screen_x) && $stable(o_screen_y))
        else $error("stalled result beat changed");

endmodule

bind world_to_screen_projection w2s_checker u_w2s_checker (.*);
